FILE: rtl/cpts_pkg.sv
package cpts_pkg;

  localparam int TASK_SLOTS_DEF    = 64;
  localparam int PRIORITY_BITS_DEF = 8;

  // fixed word field widths
  localparam int CMD_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int PRIO_IN_W  = 8;
  localparam int CNT_IN_W   = 9;
  localparam int TASK_OUT_W = 6;

  // preemption-disable depth
  localparam int DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_YIELD = 3'd1,
    CMD_PDIS  = 3'd2,
    CMD_PEN   = 3'd3,
    CMD_WRITE = 3'd4
  } cmd_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_DEC,
    OP_INC,
    OP_RCH,
    OP_CMP
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CUR_RD,
    ST_CUR,
    ST_SCAN,
    ST_RECH,
    ST_PICK,
    ST_FIN_RD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_req_t;

  typedef struct packed {
    logic [TASK_OUT_W-1:0] current_task;
    logic                  switched;
    logic                  recharged;
    logic [CNT_IN_W-1:0]   current_counter;
  } result_t;

  // shared unit width: wide enough for a counter or a depth
  function automatic int unit_w(input int pb);
    return (pb + 1 > DEPTH_W) ? pb + 1 : DEPTH_W;
  endfunction

endpackage

FILE: rtl/cpts_if.sv
interface cpts_req_if;
  logic                           valid;
  logic                           ready;
  logic [cpts_pkg::CMD_W-1:0]     command;
  logic [cpts_pkg::SLOT_W-1:0]    slot;
  logic                           slot_present;
  logic                           slot_running;
  logic [cpts_pkg::PRIO_IN_W-1:0] slot_priority;
  logic [cpts_pkg::CNT_IN_W-1:0]  slot_counter;

  modport source (
    output valid, command, slot, slot_present, slot_running, slot_priority, slot_counter,
    input  ready
  );
  modport sink (
    input  valid, command, slot, slot_present, slot_running, slot_priority, slot_counter,
    output ready
  );
endinterface

interface cpts_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [cpts_pkg::TASK_OUT_W-1:0] current_task;
  logic                            switched;
  logic                            recharged;
  logic [cpts_pkg::CNT_IN_W-1:0]   current_counter;

  modport source (
    output valid, current_task, switched, recharged, current_counter,
    input  ready
  );
  modport sink (
    input  valid, current_task, switched, recharged, current_counter,
    output ready
  );
endinterface

FILE: rtl/cpts_table.sv
module cpts_table #(
  parameter int TASK_SLOTS    = cpts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cpts_pkg::tbl_req_t              req,
  input  logic [$clog2(TASK_SLOTS)-1:0]   raddr,
  input  logic [$clog2(TASK_SLOTS)-1:0]   waddr,
  input  logic                            w_present,
  input  logic                            w_running,
  input  logic [PRIORITY_BITS-1:0]        w_prio,
  input  logic [PRIORITY_BITS:0]          w_cnt,
  input  logic [cpts_pkg::DEPTH_W-1:0]    w_depth,
  output logic                            r_present,
  output logic                            r_running,
  output logic [PRIORITY_BITS-1:0]        r_prio,
  output logic [PRIORITY_BITS:0]          r_cnt,
  output logic [cpts_pkg::DEPTH_W-1:0]    r_depth
);
  import cpts_pkg::*;

  localparam int CW = PRIORITY_BITS + 1;
  localparam int EW = 2 + PRIORITY_BITS + CW + DEPTH_W;

  logic [EW-1:0]         mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld;
  logic [EW-1:0]         rword;
  logic                  rvld;
  logic                  rzero;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[waddr] <= {w_present, w_running, w_prio, w_cnt, w_depth};
    end
    if (req.rd) begin
      rword <= mem[raddr];
      rzero <= (raddr == '0);
    end
  end

  // per-entry valid: unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (req.wr) vld[waddr] <= 1'b1;
      if (req.rd) rvld <= vld[raddr];
    end
  end

  always_comb begin
    if (rvld) begin
      r_present = rword[EW-1];
      r_running = rword[EW-2];
      r_prio    = rword[EW-3 -: PRIORITY_BITS];
      r_cnt     = rword[DEPTH_W +: CW];
      r_depth   = rword[DEPTH_W-1:0];
    end else begin
      r_present = rzero;
      r_running = rzero;
      r_prio    = PRIORITY_BITS'(rzero);
      r_cnt     = '0;
      r_depth   = '0;
    end
  end

endmodule

FILE: rtl/cpts_unit.sv
module cpts_unit #(
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input  cpts_pkg::op_t                                  op,
  input  logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0]     a,
  input  logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0]     b,
  input  logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0]     lim,
  output logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0]     res,
  output logic                                           gt
);
  import cpts_pkg::*;

  localparam int W = unit_w(PRIORITY_BITS);

  logic         sub;
  logic [W:0]   bx;
  logic [W:0]   sum;

  // one adder: a + b, or a - b as a + ~b + 1; bit W is carry (a >= b on subtract)
  always_comb begin
    sub = (op == OP_DEC) || (op == OP_CMP);
    bx  = sub ? {1'b0, ~b} : {1'b0, b};
    sum = {1'b0, a} + bx + {{W{1'b0}}, sub};
    gt  = sum[W] && (sum[W-1:0] != '0);
    unique case (op)
      OP_DEC:         res = sum[W] ? sum[W-1:0] : '0;
      OP_INC, OP_RCH: res = (sum > {1'b0, lim}) ? lim : sum[W-1:0];
      OP_CMP:         res = sum[W-1:0];
    endcase
  end

endmodule

FILE: rtl/cpts_ctrl.sv
module cpts_ctrl #(
  parameter int TASK_SLOTS    = cpts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       take,
  input  logic [cpts_pkg::CMD_W-1:0]                 command,
  input  logic [cpts_pkg::SLOT_W-1:0]                slot,
  input  logic                                       slot_present,
  input  logic                                       slot_running,
  input  logic [cpts_pkg::PRIO_IN_W-1:0]             slot_priority,
  input  logic [cpts_pkg::CNT_IN_W-1:0]              slot_counter,
  output logic                                       idle,
  output cpts_pkg::tbl_req_t                         treq,
  output logic [$clog2(TASK_SLOTS)-1:0]              raddr,
  output logic [$clog2(TASK_SLOTS)-1:0]              waddr,
  output logic                                       w_present,
  output logic                                       w_running,
  output logic [PRIORITY_BITS-1:0]                   w_prio,
  output logic [PRIORITY_BITS:0]                     w_cnt,
  output logic [cpts_pkg::DEPTH_W-1:0]               w_depth,
  input  logic                                       r_present,
  input  logic                                       r_running,
  input  logic [PRIORITY_BITS-1:0]                   r_prio,
  input  logic [PRIORITY_BITS:0]                     r_cnt,
  input  logic [cpts_pkg::DEPTH_W-1:0]               r_depth,
  output cpts_pkg::op_t                              op,
  output logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0] a,
  output logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0] b,
  output logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0] lim,
  input  logic [cpts_pkg::unit_w(PRIORITY_BITS)-1:0] u_res,
  input  logic                                       u_gt,
  input  logic                                       res_free,
  output logic                                       fin,
  output cpts_pkg::result_t                          res_word
);
  import cpts_pkg::*;

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int PTR_W = IDX_W + 1;
  localparam int CW    = PRIORITY_BITS + 1;
  localparam int UW    = unit_w(PRIORITY_BITS);
  localparam logic [CW-1:0]    CNT_MAX = '1;
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(TASK_SLOTS);

  state_t state, state_next;

  logic [CMD_W-1:0]         cmd_q;
  logic                     slot_ok_q;
  logic [IDX_W-1:0]         slot_q;
  logic                     pres_q;
  logic                     run_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [CW-1:0]            cnt_q;

  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] pick;
  logic [IDX_W-1:0] ridx;
  logic [PTR_W-1:0] rp;
  logic             pend;
  logic             any;
  logic             second;
  logic             sw;
  logic             rch;
  logic [CW-1:0]    best;
  logic             rp_more;
  logic             scan_end;
  logic             hit;

  assign rp_more  = (rp != LAST_P);
  assign scan_end = !rp_more && !pend;
  assign hit      = pend && r_present && r_running && (!any || u_gt);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (command == CMD_WRITE) begin
            state_next = ST_WRITE;
          end else if (command == CMD_TICK || command == CMD_YIELD ||
                       command == CMD_PDIS || command == CMD_PEN) begin
            state_next = ST_CUR_RD;
          end else begin
            state_next = ST_FIN_RD;
          end
        end
      end
      ST_WRITE:  state_next = ST_FIN_RD;
      ST_CUR_RD: state_next = ST_CUR;
      ST_CUR: begin
        if (cmd_q == CMD_YIELD) begin
          state_next = ST_SCAN;
        end else if (cmd_q == CMD_TICK && u_res == '0 && r_depth == '0) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FIN_RD;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = (!second && any && best == '0) ? ST_RECH : ST_PICK;
        end
      end
      ST_RECH: begin
        if (scan_end) state_next = ST_SCAN;
      end
      ST_PICK:   state_next = ST_FIN_RD;
      ST_FIN_RD: state_next = ST_FIN;
      ST_FIN: begin
        if (res_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    treq      = '0;
    raddr     = cur;
    waddr     = cur;
    w_present = r_present;
    w_running = r_running;
    w_prio    = r_prio;
    w_cnt     = r_cnt;
    w_depth   = r_depth;
    op        = OP_CMP;
    a         = '0;
    b         = '0;
    lim       = '0;
    idle      = 1'b0;
    fin       = 1'b0;
    res_word.current_task    = TASK_OUT_W'(cur);
    res_word.switched        = sw;
    res_word.recharged       = rch;
    res_word.current_counter = CNT_IN_W'(r_cnt);
    unique case (state)
      ST_IDLE: idle = 1'b1;
      ST_WRITE: begin
        treq.wr   = slot_ok_q;
        waddr     = slot_q;
        w_present = pres_q;
        w_running = run_q;
        w_prio    = (prio_q == '0) ? PRIORITY_BITS'(1) : prio_q;
        w_cnt     = cnt_q;
        w_depth   = '0;
      end
      ST_CUR_RD, ST_FIN_RD: treq.rd = 1'b1;
      ST_CUR: begin
        treq.wr = 1'b1;
        unique case (cmd_q)
          CMD_TICK: begin
            op    = OP_DEC;
            a     = UW'(r_cnt);
            b     = UW'(1);
            w_cnt = CW'(u_res);
          end
          CMD_YIELD: w_cnt = '0;
          CMD_PDIS: begin
            op      = OP_INC;
            a       = UW'(r_depth);
            b       = UW'(1);
            lim     = UW'(DEPTH_MAX);
            w_depth = DEPTH_W'(u_res);
          end
          CMD_PEN: begin
            op      = OP_DEC;
            a       = UW'(r_depth);
            b       = UW'(1);
            w_depth = DEPTH_W'(u_res);
          end
          default: treq.wr = 1'b0;
        endcase
      end
      ST_SCAN: begin
        treq.rd = rp_more;
        raddr   = rp[IDX_W-1:0];
        op      = OP_CMP;
        a       = UW'(r_cnt);
        b       = UW'(best);
      end
      ST_RECH: begin
        // read slot rp while writing back slot ridx
        treq.rd = rp_more;
        raddr   = rp[IDX_W-1:0];
        treq.wr = pend && r_present;
        waddr   = ridx;
        op      = OP_RCH;
        a       = UW'(r_cnt >> 1);
        b       = UW'(r_prio);
        lim     = UW'(CNT_MAX);
        w_cnt   = CW'(u_res);
      end
      ST_PICK: ;
      ST_FIN:  fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cur    <= '0;
      rp     <= '0;
      pend   <= 1'b0;
      any    <= 1'b0;
      second <= 1'b0;
      sw     <= 1'b0;
      rch    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && take) begin
        sw     <= 1'b0;
        rch    <= 1'b0;
        second <= 1'b0;
      end
      if (state_next != state) begin
        rp   <= '0;
        pend <= 1'b0;
      end else if (state == ST_SCAN || state == ST_RECH) begin
        pend <= rp_more;
        if (rp_more) rp <= rp + 1'b1;
      end
      if (state_next == ST_SCAN && state != ST_SCAN) begin
        any <= 1'b0;
      end else if (state == ST_SCAN && hit) begin
        any <= 1'b1;
      end
      if (state == ST_RECH && state_next == ST_SCAN) begin
        second <= 1'b1;
        rch    <= 1'b1;
      end
      if (state == ST_PICK) begin
        sw  <= (pick != cur);
        cur <= pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      cmd_q     <= command;
      slot_ok_q <= (int'(slot) < TASK_SLOTS);
      slot_q    <= IDX_W'(slot);
      pres_q    <= slot_present;
      run_q     <= slot_running;
      prio_q    <= PRIORITY_BITS'(slot_priority);
      cnt_q     <= CW'(slot_counter);
    end
    ridx <= rp[IDX_W-1:0];
    if (state_next == ST_SCAN && state != ST_SCAN) begin
      best <= '0;
      pick <= '0;
    end else if (state == ST_SCAN && hit) begin
      best <= r_cnt;
      pick <= ridx;
    end
  end

endmodule

FILE: rtl/counter_priority_task_scheduler_unit.sv
// From the accepting edge to rsp.valid: an unknown command reads the table and loads its
//   result; a write first writes its slot; a preempt or a tick without reschedule first
//   updates the current slot; a reschedule adds table passes: a scan, or scan, recharge, scan.
// Throughput: one word at a time, the next taken at the edge after its result is loaded;
//   the task table's single read port, one slot a cycle, sets the reschedule length.
// Reset (rst, synchronous): slot 0 present and running with priority 1, current task 0.
module counter_priority_task_scheduler_unit #(
  parameter int TASK_SLOTS    = cpts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  cpts_req_if.sink     req,
  cpts_rsp_if.source   rsp
);
  import cpts_pkg::*;

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CW    = PRIORITY_BITS + 1;
  localparam int UW    = unit_w(PRIORITY_BITS);

  logic take;
  logic idle;
  logic fin;
  logic res_free;
  logic out_valid;
  result_t res_word;
  result_t res_q;

  // task table port
  tbl_req_t                 treq;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         waddr;
  logic                     w_present;
  logic                     w_running;
  logic [PRIORITY_BITS-1:0] w_prio;
  logic [CW-1:0]            w_cnt;
  logic [DEPTH_W-1:0]       w_depth;
  logic                     r_present;
  logic                     r_running;
  logic [PRIORITY_BITS-1:0] r_prio;
  logic [CW-1:0]            r_cnt;
  logic [DEPTH_W-1:0]       r_depth;

  // shared add/compare unit
  op_t           op;
  logic [UW-1:0] a;
  logic [UW-1:0] b;
  logic [UW-1:0] lim;
  logic [UW-1:0] u_res;
  logic          u_gt;

  assign req.ready = idle;
  assign take      = req.valid && req.ready;

  cpts_ctrl #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .command       (req.command),
    .slot          (req.slot),
    .slot_present  (req.slot_present),
    .slot_running  (req.slot_running),
    .slot_priority (req.slot_priority),
    .slot_counter  (req.slot_counter),
    .idle          (idle),
    .treq          (treq),
    .raddr         (raddr),
    .waddr         (waddr),
    .w_present     (w_present),
    .w_running     (w_running),
    .w_prio        (w_prio),
    .w_cnt         (w_cnt),
    .w_depth       (w_depth),
    .r_present     (r_present),
    .r_running     (r_running),
    .r_prio        (r_prio),
    .r_cnt         (r_cnt),
    .r_depth       (r_depth),
    .op            (op),
    .a             (a),
    .b             (b),
    .lim           (lim),
    .u_res         (u_res),
    .u_gt          (u_gt),
    .res_free      (res_free),
    .fin           (fin),
    .res_word      (res_word)
  );

  cpts_table #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .req       (treq),
    .raddr     (raddr),
    .waddr     (waddr),
    .w_present (w_present),
    .w_running (w_running),
    .w_prio    (w_prio),
    .w_cnt     (w_cnt),
    .w_depth   (w_depth),
    .r_present (r_present),
    .r_running (r_running),
    .r_prio    (r_prio),
    .r_cnt     (r_cnt),
    .r_depth   (r_depth)
  );

  cpts_unit #(
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_unit (
    .op  (op),
    .a   (a),
    .b   (b),
    .lim (lim),
    .res (u_res),
    .gt  (u_gt)
  );

  // result register: decouples the result word from the next request
  assign res_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && res_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && res_free) res_q <= res_word;
  end

  assign rsp.valid           = out_valid;
  assign rsp.current_task    = res_q.current_task;
  assign rsp.switched        = res_q.switched;
  assign rsp.recharged       = res_q.recharged;
  assign rsp.current_counter = res_q.current_counter;

endmodule

FILE: rtl/cpts_chk.sv
module cpts_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [cpts_pkg::TASK_OUT_W-1:0] current_task,
  input logic                            switched,
  input logic                            recharged,
  input logic [cpts_pkg::CNT_IN_W-1:0]   current_counter
);

  // one word in flight: busy right after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready after accepting a word");

  // a result appears only at the end of a busy period
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result without work");

  // after reset: idle, no result pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("bad state after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(current_task) && $stable(switched) &&
      $stable(recharged) && $stable(current_counter))
    else $error("stalled result changed");

endmodule

bind counter_priority_task_scheduler_unit cpts_chk u_cpts_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .current_task    (rsp.current_task),
  .switched        (rsp.switched),
  .recharged       (rsp.recharged),
  .current_counter (rsp.current_counter)
);
